### rtl/pmer_pkg.sv
// ----------------------------------------------------------------------------
// Patterned midpoint ellipse rasterizer package
// Shared constants, command and status types between controller and datapath.
// ----------------------------------------------------------------------------
package pmer_pkg;

    localparam int DEFAULT_COORD_BITS   = 12;
    localparam int DEFAULT_RADIUS_BITS  = 10;
    localparam int DEFAULT_PATTERN_BITS = 4;

    // Decision variable (four times the textbook value) and the gradient terms.
    localparam int DEC_BITS  = 44;
    localparam int TERM_BITS = 33;

    // Request operation codes.
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Operand pairs of the shared multiplier.
    typedef logic [3:0] mul_sel_t;
    localparam mul_sel_t MUL_NONE  = 4'd0;
    localparam mul_sel_t MUL_RX2   = 4'd1;
    localparam mul_sel_t MUL_RY2   = 4'd2;
    localparam mul_sel_t MUL_A2_YN = 4'd3;
    localparam mul_sel_t MUL_B2_XN = 4'd4;
    localparam mul_sel_t MUL_SQX   = 4'd5;
    localparam mul_sel_t MUL_SQY   = 4'd6;
    localparam mul_sel_t MUL_B2_P  = 4'd7;
    localparam mul_sel_t MUL_A2_P  = 4'd8;
    localparam mul_sel_t MUL_A2_B2 = 4'd9;

    // Decision accumulator operations.
    typedef logic [1:0] acc_op_t;
    localparam acc_op_t ACC_HOLD = 2'd0;
    localparam acc_op_t ACC_LOAD = 2'd1;
    localparam acc_op_t ACC_ADD  = 2'd2;
    localparam acc_op_t ACC_SUB  = 2'd3;

    typedef logic [1:0] acc_src_t;
    localparam acc_src_t SRC_PROD = 2'd0;
    localparam acc_src_t SRC_A2   = 2'd1;
    localparam acc_src_t SRC_B2   = 2'd2;

    typedef logic [1:0] acc_shift_t;
    localparam acc_shift_t SHIFT_X1 = 2'd0;
    localparam acc_shift_t SHIFT_X4 = 2'd2;
    localparam acc_shift_t SHIFT_X8 = 2'd3;

    // Mirror index of an emitted point.
    typedef logic [1:0] point_idx_t;
    localparam point_idx_t FIRST_POINT = 2'd0;
    localparam point_idx_t LAST_POINT  = 2'd3;

    typedef struct packed {
        logic       start;
        logic       step;
        logic       prep;
        logic       set_region2;
        logic       ld_a2;
        logic       ld_b2;
        logic       ld_term_x;
        logic       ld_term_y;
        logic       commit_pos;
        mul_sel_t   mul_sel;
        acc_op_t    acc_op;
        acc_src_t   acc_src;
        acc_shift_t acc_shift;
        logic       emit;
        point_idx_t emit_idx;
    } pmer_cmd_t;

    typedef struct packed {
        logic done;
        logic need_switch;
        logic region2;
        logic inc_x;
        logic dec_y;
        logic out_free;
    } pmer_status_t;

endpackage

### rtl/patterned_midpoint_ellipse_rasterizer.sv
// ----------------------------------------------------------------------------
// Patterned midpoint ellipse rasterizer
// Two-region midpoint ellipse walker with dash-pattern masking of the points.
// ----------------------------------------------------------------------------
// Requests arrive on in_valid/in_stall. A start request loads the center and
// the radii; a step request advances one position. Every request returns four
// mirrored points on out_valid/out_stall, the fourth flagged by last_of_step.
// The dash pattern is written through cfg_we/cfg_data; the user must do so
// only while the block is idle, which the block itself does not enforce.
// A step request is accepted, passes the step update states and then emits
// its four points; the step that enters region two first passes the
// region-two entry states, and a start passes the start states before its
// points. A step after the ellipse is finished goes straight to its four
// masked points. This sequence is set by the single shared multiplier,
// which the controller walks through the products in turn, and by the one
// output register, which issues one point per cycle while the receiver does
// not stall. A stalling receiver holds the output register and the
// controller waits in its emit state; the next request is taken while the
// last point of the previous one still waits. Reset leaves the block idle
// with nothing drawn, the pattern all ones and the output channel empty.
// ----------------------------------------------------------------------------
module patterned_midpoint_ellipse_rasterizer #(
    parameter int COORD_BITS   = pmer_pkg::DEFAULT_COORD_BITS,
    parameter int RADIUS_BITS  = pmer_pkg::DEFAULT_RADIUS_BITS,
    parameter int PATTERN_BITS = pmer_pkg::DEFAULT_PATTERN_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [PATTERN_BITS-1:0]      cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         operation,
    input  logic signed [COORD_BITS-1:0] center_x,
    input  logic signed [COORD_BITS-1:0] center_y,
    input  logic [RADIUS_BITS-1:0]       semi_axis_x,
    input  logic [RADIUS_BITS-1:0]       semi_axis_y,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [COORD_BITS:0]   point_x,
    output logic signed [COORD_BITS:0]   point_y,
    output logic                         visible,
    output logic                         last_of_step,
    output logic                         finished
);
    import pmer_pkg::*;

    pmer_cmd_t    cmd;
    pmer_status_t status;

    pmer_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .in_stall  (in_stall),
        .status    (status),
        .cmd       (cmd)
    );

    pmer_dp #(
        .COORD_BITS   (COORD_BITS),
        .RADIUS_BITS  (RADIUS_BITS),
        .PATTERN_BITS (PATTERN_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .center_x     (center_x),
        .center_y     (center_y),
        .semi_axis_x  (semi_axis_x),
        .semi_axis_y  (semi_axis_y),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .point_x      (point_x),
        .point_y      (point_y),
        .visible      (visible),
        .last_of_step (last_of_step),
        .finished     (finished)
    );

endmodule

### rtl/pmer_dp.sv
// ----------------------------------------------------------------------------
// Ellipse rasterizer datapath
// Shared multiplier, decision accumulator, position state and output register.
// ----------------------------------------------------------------------------
module pmer_dp #(
    parameter int COORD_BITS   = pmer_pkg::DEFAULT_COORD_BITS,
    parameter int RADIUS_BITS  = pmer_pkg::DEFAULT_RADIUS_BITS,
    parameter int PATTERN_BITS = pmer_pkg::DEFAULT_PATTERN_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pmer_pkg::pmer_cmd_t            cmd,
    output pmer_pkg::pmer_status_t         status,
    input  logic                           cfg_we,
    input  logic [PATTERN_BITS-1:0]        cfg_data,
    input  logic signed [COORD_BITS-1:0]   center_x,
    input  logic signed [COORD_BITS-1:0]   center_y,
    input  logic [RADIUS_BITS-1:0]         semi_axis_x,
    input  logic [RADIUS_BITS-1:0]         semi_axis_y,
    input  logic                           out_stall,
    output logic                           out_valid,
    output logic signed [COORD_BITS:0]     point_x,
    output logic signed [COORD_BITS:0]     point_y,
    output logic                           visible,
    output logic                           last_of_step,
    output logic                           finished
);
    import pmer_pkg::*;

    localparam int POS_BITS   = RADIUS_BITS + 1;
    localparam int OUT_BITS   = COORD_BITS + 1;
    localparam int SQ_BITS    = 2 * RADIUS_BITS;
    localparam int MUL_A_BITS = SQ_BITS;
    localparam int MUL_B_BITS = 2 * (POS_BITS + 1);
    localparam int IDX_BITS   = (PATTERN_BITS > 1) ? $clog2(PATTERN_BITS) : 1;
    localparam int EXT_BITS   = ((POS_BITS > COORD_BITS) ? POS_BITS : COORD_BITS) + 2;
    localparam logic [IDX_BITS-1:0] IDX_TOP = IDX_BITS'(PATTERN_BITS - 1);

    // Control state.
    logic [PATTERN_BITS-1:0]      dash_reg;
    logic [IDX_BITS-1:0]          idx_reg;
    logic                         region2_reg;
    logic                         done_reg;
    logic                         out_valid_reg;

    // Geometry state.
    logic signed [COORD_BITS-1:0] cx_reg;
    logic signed [COORD_BITS-1:0] cy_reg;
    logic [POS_BITS-1:0]          pos_x_reg;
    logic [POS_BITS-1:0]          pos_y_reg;
    logic [RADIUS_BITS-1:0]       rx_reg;
    logic [RADIUS_BITS-1:0]       ry_reg;
    logic [SQ_BITS-1:0]           a2_reg;
    logic [SQ_BITS-1:0]           b2_reg;
    logic [POS_BITS:0]            x_new_reg;
    logic [POS_BITS-1:0]          y_new_reg;
    logic                         inc_x_reg;
    logic                         dec_y_reg;
    logic                         vis_reg;
    logic [DEC_BITS-1:0]          dec_reg;
    logic [TERM_BITS-1:0]         term_x_reg;
    logic [TERM_BITS-1:0]         term_y_reg;
    logic [DEC_BITS-1:0]          prod_reg;

    // Output payload.
    logic signed [OUT_BITS-1:0]   point_x_reg;
    logic signed [OUT_BITS-1:0]   point_y_reg;
    logic                         visible_reg;
    logic                         last_reg;
    logic                         finished_reg;

    logic [MUL_A_BITS-1:0]        mul_a;
    logic [MUL_B_BITS-1:0]        mul_b;
    logic [MUL_A_BITS+MUL_B_BITS-1:0] prod_full;
    logic [POS_BITS:0]            odd_x;
    logic [POS_BITS-1:0]          y_less;
    logic [DEC_BITS-1:0]          add_src;
    logic [DEC_BITS-1:0]          addend;
    logic [DEC_BITS-1:0]          dec_next;
    logic [SQ_BITS+POS_BITS:0]    b2_wrap;
    logic [TERM_BITS-1:0]         twice_prod;
    logic [TERM_BITS-1:0]         wrap_corr;
    logic [TERM_BITS-1:0]         term_x_next;
    logic [POS_BITS:0]            x_new_next;
    logic [POS_BITS-1:0]          y_new_next;
    logic                         inc_x_next;
    logic                         dec_y_next;
    logic [IDX_BITS-1:0]          idx_next;
    logic signed [EXT_BITS-1:0]   mag_x;
    logic signed [EXT_BITS-1:0]   mag_y;
    logic signed [EXT_BITS-1:0]   cen_x;
    logic signed [EXT_BITS-1:0]   cen_y;
    logic signed [EXT_BITS-1:0]   sum_x;
    logic signed [EXT_BITS-1:0]   sum_y;

    assign odd_x  = {pos_x_reg, 1'b1};
    assign y_less = pos_y_reg - POS_BITS'(1);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_sel)
            MUL_RX2:
            begin
                mul_a = MUL_A_BITS'(rx_reg);
                mul_b = MUL_B_BITS'(rx_reg);
            end
            MUL_RY2:
            begin
                mul_a = MUL_A_BITS'(ry_reg);
                mul_b = MUL_B_BITS'(ry_reg);
            end
            MUL_A2_YN:
            begin
                mul_a = a2_reg;
                mul_b = MUL_B_BITS'(y_new_reg);
            end
            MUL_B2_XN:
            begin
                mul_a = b2_reg;
                mul_b = MUL_B_BITS'(x_new_reg);
            end
            MUL_SQX:
            begin
                mul_a = MUL_A_BITS'(odd_x);
                mul_b = MUL_B_BITS'(odd_x);
            end
            MUL_SQY:
            begin
                mul_a = MUL_A_BITS'(y_less);
                mul_b = MUL_B_BITS'(y_less);
            end
            MUL_B2_P:
            begin
                mul_a = b2_reg;
                mul_b = prod_reg[MUL_B_BITS-1:0];
            end
            MUL_A2_P:
            begin
                mul_a = a2_reg;
                mul_b = prod_reg[MUL_B_BITS-1:0];
            end
            MUL_A2_B2:
            begin
                mul_a = a2_reg;
                mul_b = MUL_B_BITS'(b2_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_full = mul_a * mul_b;

    always_comb
    begin
        case (cmd.acc_src)
            SRC_A2:  add_src = DEC_BITS'(a2_reg);
            SRC_B2:  add_src = DEC_BITS'(b2_reg);
            default: add_src = prod_reg;
        endcase
        addend = add_src << cmd.acc_shift;
        unique case (cmd.acc_op)
            ACC_LOAD: dec_next = addend;
            ACC_ADD:  dec_next = dec_reg + addend;
            ACC_SUB:  dec_next = dec_reg - addend;
            default:  dec_next = dec_reg;
        endcase
    end

    // The position register keeps x modulo its width; the gradient term follows it.
    assign b2_wrap     = {b2_reg, {(POS_BITS + 1){1'b0}}};
    assign twice_prod  = {prod_reg[TERM_BITS-2:0], 1'b0};
    assign wrap_corr   = x_new_reg[POS_BITS] ? TERM_BITS'(b2_wrap) : '0;
    assign term_x_next = twice_prod - wrap_corr;

    // Region one always moves x; region two always moves y.
    always_comb
    begin
        if (region2_reg)
        begin
            inc_x_next = dec_reg[DEC_BITS-1];
            dec_y_next = 1'b1;
        end
        else
        begin
            inc_x_next = 1'b1;
            dec_y_next = ~dec_reg[DEC_BITS-1];
        end
        x_new_next = {1'b0, pos_x_reg} + (POS_BITS + 1)'(inc_x_next);
        y_new_next = pos_y_reg - POS_BITS'(dec_y_next);
        idx_next   = (idx_reg == '0) ? IDX_TOP : idx_reg - IDX_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dash_reg      <= '1;
            idx_reg       <= IDX_TOP;
            region2_reg   <= 1'b0;
            done_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                dash_reg <= cfg_data;
            end
            if (cmd.start)
            begin
                cx_reg      <= center_x;
                cy_reg      <= center_y;
                pos_x_reg   <= '0;
                pos_y_reg   <= POS_BITS'(semi_axis_y);
                region2_reg <= 1'b0;
                idx_reg     <= IDX_TOP;
                done_reg    <= (semi_axis_y == '0);
            end
            else if (cmd.commit_pos)
            begin
                pos_x_reg <= x_new_reg[POS_BITS-1:0];
                pos_y_reg <= y_new_reg;
                done_reg  <= (y_new_reg == '0);
            end
            if (cmd.step && !done_reg)
            begin
                idx_reg <= idx_next;
            end
            if (cmd.set_region2)
            begin
                region2_reg <= 1'b1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= DEC_BITS'(prod_full);
        dec_reg  <= dec_next;
        if (cmd.start)
        begin
            rx_reg    <= semi_axis_x;
            ry_reg    <= semi_axis_y;
            x_new_reg <= '0;
            y_new_reg <= POS_BITS'(semi_axis_y);
            vis_reg   <= dash_reg[IDX_TOP];
        end
        if (cmd.step)
        begin
            vis_reg <= dash_reg[idx_reg] & ~done_reg;
        end
        if (cmd.prep)
        begin
            x_new_reg <= x_new_next;
            y_new_reg <= y_new_next;
            inc_x_reg <= inc_x_next;
            dec_y_reg <= dec_y_next;
        end
        if (cmd.ld_a2)
        begin
            a2_reg <= prod_reg[SQ_BITS-1:0];
        end
        if (cmd.ld_b2)
        begin
            b2_reg <= prod_reg[SQ_BITS-1:0];
        end
        if (cmd.ld_term_x)
        begin
            term_x_reg <= term_x_next;
        end
        if (cmd.ld_term_y)
        begin
            term_y_reg <= twice_prod;
        end
    end

    // Mirror order: (x, y), (x, -y), (-x, -y), (-x, y).
    always_comb
    begin
        mag_x = EXT_BITS'(pos_x_reg);
        mag_y = EXT_BITS'(pos_y_reg);
        cen_x = EXT_BITS'(cx_reg);
        cen_y = EXT_BITS'(cy_reg);
        sum_x = cmd.emit_idx[1] ? cen_x - mag_x : cen_x + mag_x;
        sum_y = (cmd.emit_idx[1] ^ cmd.emit_idx[0]) ? cen_y - mag_y : cen_y + mag_y;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            point_x_reg  <= sum_x[OUT_BITS-1:0];
            point_y_reg  <= sum_y[OUT_BITS-1:0];
            visible_reg  <= vis_reg;
            last_reg     <= (cmd.emit_idx == LAST_POINT);
            finished_reg <= done_reg;
        end
    end

    assign status.done        = done_reg;
    assign status.need_switch = ~region2_reg & ~(term_x_reg < term_y_reg);
    assign status.region2     = region2_reg;
    assign status.inc_x       = inc_x_reg;
    assign status.dec_y       = dec_y_reg;
    assign status.out_free    = ~out_valid_reg | ~out_stall;

    assign out_valid    = out_valid_reg;
    assign point_x      = point_x_reg;
    assign point_y      = point_y_reg;
    assign visible      = visible_reg;
    assign last_of_step = last_reg;
    assign finished     = finished_reg;

endmodule

### rtl/pmer_ctrl.sv
// ----------------------------------------------------------------------------
// Ellipse rasterizer controller
// Sequences the shared multiplier and accumulator for start, region switch
// and step requests, then emits the four mirrored points.
// ----------------------------------------------------------------------------
module pmer_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   operation,
    output logic                   in_stall,
    input  pmer_pkg::pmer_status_t status,
    output pmer_pkg::pmer_cmd_t    cmd
);
    import pmer_pkg::*;

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_START1 = 5'd1;
    localparam logic [4:0] ST_START2 = 5'd2;
    localparam logic [4:0] ST_START3 = 5'd3;
    localparam logic [4:0] ST_START4 = 5'd4;
    localparam logic [4:0] ST_START5 = 5'd5;
    localparam logic [4:0] ST_INIT1  = 5'd6;
    localparam logic [4:0] ST_INIT2  = 5'd7;
    localparam logic [4:0] ST_INIT3  = 5'd8;
    localparam logic [4:0] ST_INIT4  = 5'd9;
    localparam logic [4:0] ST_INIT5  = 5'd10;
    localparam logic [4:0] ST_INIT6  = 5'd11;
    localparam logic [4:0] ST_INIT7  = 5'd12;
    localparam logic [4:0] ST_STEP1  = 5'd13;
    localparam logic [4:0] ST_STEP2  = 5'd14;
    localparam logic [4:0] ST_STEP3  = 5'd15;
    localparam logic [4:0] ST_EMIT   = 5'd16;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    point_idx_t k_reg;
    point_idx_t k_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (operation == OP_START)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_START1;
                    end
                    else
                    begin
                        cmd.step = 1'b1;
                        if (status.done)
                        begin
                            state_next = ST_EMIT;
                        end
                        else if (status.need_switch)
                        begin
                            state_next = ST_INIT1;
                        end
                        else
                        begin
                            cmd.prep   = 1'b1;
                            state_next = ST_STEP1;
                        end
                    end
                end
            end
            // Start: d = rx^2 - 4*rx^2*ry + 4*ry^2, terms from x = 0 and y = ry.
            ST_START1:
            begin
                cmd.mul_sel = MUL_RX2;
                state_next  = ST_START2;
            end
            ST_START2:
            begin
                cmd.ld_a2   = 1'b1;
                cmd.mul_sel = MUL_RY2;
                state_next  = ST_START3;
            end
            ST_START3:
            begin
                cmd.ld_b2     = 1'b1;
                cmd.acc_op    = ACC_LOAD;
                cmd.acc_src   = SRC_A2;
                cmd.acc_shift = SHIFT_X1;
                cmd.mul_sel   = MUL_A2_YN;
                state_next    = ST_START4;
            end
            ST_START4:
            begin
                cmd.acc_op    = ACC_SUB;
                cmd.acc_src   = SRC_PROD;
                cmd.acc_shift = SHIFT_X4;
                cmd.ld_term_y = 1'b1;
                cmd.mul_sel   = MUL_B2_XN;
                state_next    = ST_START5;
            end
            ST_START5:
            begin
                cmd.acc_op    = ACC_ADD;
                cmd.acc_src   = SRC_B2;
                cmd.acc_shift = SHIFT_X4;
                cmd.ld_term_x = 1'b1;
                state_next    = ST_EMIT;
            end
            // Region two entry: d = ry^2*(2x+1)^2 + 4*rx^2*(y-1)^2 - 4*rx^2*ry^2.
            ST_INIT1:
            begin
                cmd.set_region2 = 1'b1;
                cmd.mul_sel     = MUL_SQX;
                state_next      = ST_INIT2;
            end
            ST_INIT2:
            begin
                cmd.mul_sel = MUL_B2_P;
                state_next  = ST_INIT3;
            end
            ST_INIT3:
            begin
                cmd.acc_op    = ACC_LOAD;
                cmd.acc_src   = SRC_PROD;
                cmd.acc_shift = SHIFT_X1;
                cmd.mul_sel   = MUL_SQY;
                state_next    = ST_INIT4;
            end
            ST_INIT4:
            begin
                cmd.mul_sel = MUL_A2_P;
                state_next  = ST_INIT5;
            end
            ST_INIT5:
            begin
                cmd.acc_op    = ACC_ADD;
                cmd.acc_src   = SRC_PROD;
                cmd.acc_shift = SHIFT_X4;
                cmd.mul_sel   = MUL_A2_B2;
                state_next    = ST_INIT6;
            end
            ST_INIT6:
            begin
                cmd.acc_op    = ACC_SUB;
                cmd.acc_src   = SRC_PROD;
                cmd.acc_shift = SHIFT_X4;
                state_next    = ST_INIT7;
            end
            ST_INIT7:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_STEP1;
            end
            // Step: d += 4*(b2 or a2) + 8*b2*x' (if x moves) - 8*a2*y' (if y moves).
            ST_STEP1:
            begin
                cmd.acc_op    = ACC_ADD;
                cmd.acc_src   = status.region2 ? SRC_A2 : SRC_B2;
                cmd.acc_shift = SHIFT_X4;
                cmd.mul_sel   = MUL_B2_XN;
                state_next    = ST_STEP2;
            end
            ST_STEP2:
            begin
                cmd.acc_op    = status.inc_x ? ACC_ADD : ACC_HOLD;
                cmd.acc_src   = SRC_PROD;
                cmd.acc_shift = SHIFT_X8;
                cmd.ld_term_x = 1'b1;
                cmd.mul_sel   = MUL_A2_YN;
                state_next    = ST_STEP3;
            end
            ST_STEP3:
            begin
                cmd.acc_op     = status.dec_y ? ACC_SUB : ACC_HOLD;
                cmd.acc_src    = SRC_PROD;
                cmd.acc_shift  = SHIFT_X8;
                cmd.ld_term_y  = 1'b1;
                cmd.commit_pos = 1'b1;
                state_next     = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_idx = k_reg;
                    if (k_reg == LAST_POINT)
                    begin
                        k_next     = FIRST_POINT;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                k_next     = FIRST_POINT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= FIRST_POINT;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

endmodule
